/* sv/ffmcd_pkg.sv */
// Shared types and constants for the fixed frame monitor command deframer.
package ffmcd_pkg;

  // Address bytes in a fixed frame and the resulting frame length.
  localparam int unsigned ADDR_BYTES = 2;
  localparam int unsigned FRAME_LEN  = ADDR_BYTES + 4;
  localparam int unsigned WIN_DEPTH  = FRAME_LEN - 1;

  localparam int unsigned FILL_W = $clog2(FRAME_LEN + 1);
  localparam int unsigned IDX_W  = $clog2(FRAME_LEN);

  // Byte positions inside a frame.
  localparam logic [IDX_W-1:0] POS_START   = IDX_W'(0);
  localparam logic [IDX_W-1:0] POS_CTRL    = IDX_W'(1);
  localparam logic [IDX_W-1:0] POS_ADDR_LO = IDX_W'(2);
  localparam logic [IDX_W-1:0] POS_ADDR_HI = IDX_W'(3);
  localparam logic [IDX_W-1:0] POS_SUM     = IDX_W'(ADDR_BYTES + 2);
  localparam logic [IDX_W-1:0] POS_END     = IDX_W'(ADDR_BYTES + 3);

  // Configuration register indexes.
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t REG_START_CODE    = 3'd0;
  localparam cfg_idx_t REG_END_CODE      = 3'd1;
  localparam cfg_idx_t REG_FC_START_MON  = 3'd2;
  localparam cfg_idx_t REG_FC_STOP_MON   = 3'd3;
  localparam cfg_idx_t REG_FC_REPLY      = 3'd4;
  localparam cfg_idx_t REG_FC_ADDR_ERROR = 3'd5;
  localparam cfg_idx_t REG_OWN_ADDR      = 3'd6;
  localparam cfg_idx_t REG_PROTOCOL_MODE = 3'd7;

  // Command outcome codes.
  typedef logic [1:0] outcome_t;
  localparam outcome_t OUT_STARTED    = 2'd0;
  localparam outcome_t OUT_ADDR_CLASH = 2'd1;
  localparam outcome_t OUT_STOPPED    = 2'd2;
  localparam outcome_t OUT_UNKNOWN    = 2'd3;

  typedef logic [7:0] byte_t;

endpackage

/* sv/fixed_frame_monitor_command_deframer.sv */
// Top level: fixed frame deframer, monitor command decoder and reply sender.
//
//  channel | direction | tdata / data          | side band
//  --------+-----------+-----------------------+------------------------------------
//  in_     | slave     | rx_byte [7:0]         | -
//  out_    | master    | tx_byte [7:0]         | tlast = last, tuser = has_byte, outcome
//  cfg_    | slave     | cfg_data [15:0]       | cfg_index [2:0], always ready
//
// One received word is taken per cycle. A byte that completes a frame is checked,
// decoded and turned into a reply job in the same cycle; the reply is then sent from a
// job register, one word per cycle while out_tready is high: six words for a reply
// frame, one word otherwise. Input stalls only when a completing byte arrives while an
// earlier reply is still being sent and its final word is not leaving this cycle.
// Reset (rst_n low, synchronous) empties the window, clears the monitor state,
// drops any pending reply and loads the configuration defaults.
module fixed_frame_monitor_command_deframer
  import ffmcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] tx_byte
  output logic        out_tlast,
  output logic [2:0]  out_tuser,   // [0] has_byte, [2:1] outcome
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_idx_t    cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers
  byte_t       start_code_r, end_code_r, fc_start_r, fc_stop_r, fc_reply_r, fc_addr_err_r;
  logic [15:0] own_addr_r;
  logic        mode_r;

  // Deframer state
  byte_t             window_r [WIN_DEPTH];
  byte_t             window_nxt [WIN_DEPTH];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [15:0]       mon_addr_r, mon_addr_nxt;
  logic              active_r, active_nxt;

  // Reply job
  logic             job_valid_r, job_valid_nxt;
  logic             job_long_r, job_long_nxt;
  byte_t            job_ctrl_r, job_ctrl_nxt;
  logic [15:0]      job_addr_r, job_addr_nxt;
  outcome_t         job_outcome_r, job_outcome_nxt;
  logic [IDX_W-1:0] job_idx_r, job_idx_nxt;

  logic in_acc, out_acc, job_done;
  byte_t rx;

  // Window with the incoming byte appended at the last position
  byte_t                 win6 [FRAME_LEN];
  logic [8*FRAME_LEN-1:0] win_flat, win_shift;
  logic [FILL_W-1:0]     skip;
  byte_t                 chk_sum;
  logic                  frame_ok;
  byte_t                 cmd_ctrl;
  logic [15:0]           cmd_addr;

  assign cfg_ready = 1'b1;
  assign rx        = in_tdata;

  assign out_tvalid = job_valid_r;
  assign out_tlast  = !job_long_r || (job_idx_r == POS_END);
  assign out_acc    = out_tvalid && out_tready;
  assign job_done   = out_acc && out_tlast;

  // Hold input only when a completing byte would meet a busy job
  assign in_tready = !job_valid_r || (fill_r != FILL_W'(WIN_DEPTH)) || job_done;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win6[i] = window_r[i];
    end
    win6[FRAME_LEN-1] = rx;
    for (int i = 0; i < FRAME_LEN; i++) begin
      win_flat[8*i +: 8] = win6[i];
    end
  end

  assign chk_sum  = win6[POS_CTRL] + win6[POS_ADDR_LO] + win6[POS_ADDR_HI];
  assign frame_ok = (win6[POS_SUM] == chk_sum) && (win6[POS_END] == end_code_r);
  assign cmd_ctrl = win6[POS_CTRL];
  assign cmd_addr = {win6[POS_ADDR_HI], win6[POS_ADDR_LO]};

  // Resync: drop the leading byte, then up to the next start byte
  always_comb begin
    skip = FILL_W'(FRAME_LEN);
    for (int i = FRAME_LEN - 1; i >= 1; i--) begin
      if (win6[i] == start_code_r) begin
        skip = FILL_W'(i);
      end
    end
  end

  assign win_shift = win_flat >> {skip, 3'b000};

  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      window_nxt[i] = window_r[i];
    end
    fill_nxt        = fill_r;
    mon_addr_nxt    = mon_addr_r;
    active_nxt      = active_r;
    job_valid_nxt   = job_valid_r;
    job_long_nxt    = job_long_r;
    job_ctrl_nxt    = job_ctrl_r;
    job_addr_nxt    = job_addr_r;
    job_outcome_nxt = job_outcome_r;
    job_idx_nxt     = job_idx_r;

    // Advance or retire the reply being sent
    if (out_acc) begin
      if (out_tlast) begin
        job_valid_nxt = 1'b0;
      end else begin
        job_idx_nxt = job_idx_r + IDX_W'(1);
      end
    end

    if (in_acc) begin
      if (fill_r != FILL_W'(WIN_DEPTH)) begin
        // Collect; drop bytes ahead of a start byte
        if (fill_r != '0 || rx == start_code_r) begin
          window_nxt[fill_r[IDX_W-1:0]] = rx;
          fill_nxt = fill_r + FILL_W'(1);
        end
      end else if (!frame_ok) begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
          window_nxt[i] = win_shift[8*i +: 8];
        end
        fill_nxt = FILL_W'(FRAME_LEN) - skip;
      end else begin
        fill_nxt      = '0;
        job_valid_nxt = 1'b1;
        job_idx_nxt   = '0;
        if (cmd_ctrl == fc_start_r) begin
          mon_addr_nxt = cmd_addr;
          job_addr_nxt = cmd_addr;
          job_long_nxt = (cmd_addr != '0);
          if (cmd_addr != own_addr_r) begin
            active_nxt      = 1'b1;
            job_ctrl_nxt    = fc_reply_r;
            job_outcome_nxt = OUT_STARTED;
          end else begin
            job_ctrl_nxt    = fc_addr_err_r;
            job_outcome_nxt = OUT_ADDR_CLASH;
          end
        end else if (cmd_ctrl == fc_stop_r) begin
          active_nxt      = 1'b0;
          mon_addr_nxt    = cmd_addr;
          job_addr_nxt    = cmd_addr;
          job_ctrl_nxt    = fc_reply_r;
          job_long_nxt    = !mode_r && (cmd_addr != '0);
          job_outcome_nxt = OUT_STOPPED;
        end else begin
          active_nxt      = 1'b0;
          mon_addr_nxt    = '0;
          job_addr_nxt    = '0;
          job_ctrl_nxt    = '0;
          job_long_nxt    = 1'b0;
          job_outcome_nxt = OUT_UNKNOWN;
        end
      end
    end
  end

  // Reply word selection
  always_comb begin
    out_tdata = '0;
    if (job_long_r) begin
      case (job_idx_r)
        POS_START:   out_tdata = start_code_r;
        POS_CTRL:    out_tdata = job_ctrl_r;
        POS_ADDR_LO: out_tdata = job_addr_r[7:0];
        POS_ADDR_HI: out_tdata = job_addr_r[15:8];
        POS_SUM:     out_tdata = job_ctrl_r + job_addr_r[7:0] + job_addr_r[15:8];
        POS_END:     out_tdata = end_code_r;
        default:     out_tdata = '0;
      endcase
    end
  end

  assign out_tuser = {job_outcome_r, job_long_r};

  // Payload registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      window_r[i] <= window_nxt[i];
    end
    job_long_r    <= job_long_nxt;
    job_ctrl_r    <= job_ctrl_nxt;
    job_addr_r    <= job_addr_nxt;
    job_outcome_r <= job_outcome_nxt;
    job_idx_r     <= job_idx_nxt;
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r        <= '0;
      mon_addr_r    <= '0;
      active_r      <= 1'b0;
      job_valid_r   <= 1'b0;
      start_code_r  <= 8'h10;
      end_code_r    <= 8'h16;
      fc_start_r    <= 8'h01;
      fc_stop_r     <= 8'h02;
      fc_reply_r    <= 8'h00;
      fc_addr_err_r <= 8'h03;
      own_addr_r    <= 16'h0000;
      mode_r        <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      mon_addr_r  <= mon_addr_nxt;
      active_r    <= active_nxt;
      job_valid_r <= job_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_CODE:    start_code_r  <= cfg_data[7:0];
          REG_END_CODE:      end_code_r    <= cfg_data[7:0];
          REG_FC_START_MON:  fc_start_r    <= cfg_data[7:0];
          REG_FC_STOP_MON:   fc_stop_r     <= cfg_data[7:0];
          REG_FC_REPLY:      fc_reply_r    <= cfg_data[7:0];
          REG_FC_ADDR_ERROR: fc_addr_err_r <= cfg_data[7:0];
          REG_OWN_ADDR:      own_addr_r    <= cfg_data;
          REG_PROTOCOL_MODE: mode_r        <= cfg_data[0];
          default:           mode_r        <= mode_r;
        endcase
      end
    end
  end

endmodule

/* tb/fixed_frame_monitor_command_deframer_tb.sv */
// Self-checking testbench for the fixed frame monitor command deframer.
`timescale 1ns / 1ps

module fixed_frame_monitor_command_deframer_tb;
  import ffmcd_pkg::*;

  localparam int unsigned HOLD_CYCLES = 300;

  // One expected word on the result stream.
  typedef struct {
    logic     has_byte;
    byte_t    tx_byte;
    logic     last;
    outcome_t outcome;
  } reply_word_t;

  // Mirrors the deframer: window, monitor state and register copies, plus the
  // queue of reply words still owed by the block.
  class reply_scoreboard;
    byte_t       win [FRAME_LEN];
    int unsigned fill;
    logic [15:0] mon_addr;
    logic        mon_active;
    byte_t       start_code, end_code, fc_start, fc_stop, fc_reply, fc_addr_err;
    logic [15:0] own_addr;
    logic        mode;
    reply_word_t reply_q [$];
    int unsigned errors;

    function new();
      foreach (win[i]) win[i] = 8'h00;
      fill        = 0;
      mon_addr    = 16'h0000;
      mon_active  = 1'b0;
      start_code  = 8'h10;
      end_code    = 8'h16;
      fc_start    = 8'h01;
      fc_stop     = 8'h02;
      fc_reply    = 8'h00;
      fc_addr_err = 8'h03;
      own_addr    = 16'h0000;
      mode        = 1'b0;
      errors      = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] val);
      case (idx)
        REG_START_CODE:    start_code  = val[7:0];
        REG_END_CODE:      end_code    = val[7:0];
        REG_FC_START_MON:  fc_start    = val[7:0];
        REG_FC_STOP_MON:   fc_stop     = val[7:0];
        REG_FC_REPLY:      fc_reply    = val[7:0];
        REG_FC_ADDR_ERROR: fc_addr_err = val[7:0];
        REG_OWN_ADDR:      own_addr    = val;
        REG_PROTOCOL_MODE: mode        = val[0];
        default: ;
      endcase
    endfunction

    // Queue a six-word reply frame, or a single marker word when no reply goes out.
    function void queue_reply(logic want, byte_t ctrl, outcome_t oc);
      byte_t       frame [FRAME_LEN];
      reply_word_t w;
      if (want && mon_addr != 16'h0000) begin
        frame[POS_START]   = start_code;
        frame[POS_CTRL]    = ctrl;
        frame[POS_ADDR_LO] = mon_addr[7:0];
        frame[POS_ADDR_HI] = mon_addr[15:8];
        frame[POS_SUM]     = ctrl + mon_addr[7:0] + mon_addr[15:8];
        frame[POS_END]     = end_code;
        foreach (frame[k]) begin
          w.has_byte = 1'b1;
          w.tx_byte  = frame[k];
          w.last     = (k == FRAME_LEN - 1);
          w.outcome  = oc;
          reply_q.push_back(w);
        end
      end else begin
        w.has_byte = 1'b0;
        w.tx_byte  = 8'h00;
        w.last     = 1'b1;
        w.outcome  = oc;
        reply_q.push_back(w);
      end
    endfunction

    // Take one received byte: collect, check, slide or decode.
    function void deframe_byte(byte_t b);
      int unsigned k;
      int unsigned i;
      byte_t       sum;
      byte_t       ctrl;
      logic [15:0] addr;
      if (fill == 0 && b != start_code) return;
      if (fill >= FRAME_LEN) fill = 0;
      win[fill] = b;
      fill++;
      if (fill < FRAME_LEN) return;

      sum = win[POS_CTRL] + win[POS_ADDR_LO] + win[POS_ADDR_HI];
      if (win[POS_SUM] != sum || win[POS_END] != end_code) begin
        // drop the leading byte, then everything up to the next start code
        k = 1;
        while (k < fill && win[k] != start_code) k++;
        for (i = 0; i < FRAME_LEN; i++)
          win[i] = (i + k < fill) ? win[i + k] : 8'h00;
        fill = fill - k;
        return;
      end

      ctrl = win[POS_CTRL];
      addr = {win[POS_ADDR_HI], win[POS_ADDR_LO]};
      foreach (win[j]) win[j] = 8'h00;
      fill = 0;

      if (ctrl == fc_start) begin
        mon_addr = addr;
        if (addr != own_addr) begin
          mon_active = 1'b1;
          queue_reply(1'b1, fc_reply, OUT_STARTED);
        end else begin
          queue_reply(1'b1, fc_addr_err, OUT_ADDR_CLASH);
        end
      end else if (ctrl == fc_stop) begin
        mon_active = 1'b0;
        mon_addr   = addr;
        queue_reply(mode == 1'b0, fc_reply, OUT_STOPPED);
      end else begin
        mon_active = 1'b0;
        mon_addr   = 16'h0000;
        queue_reply(1'b0, 8'h00, OUT_UNKNOWN);
      end
    endfunction

    function void check_reply_word(logic [7:0] data, logic lst, logic [2:0] user);
      reply_word_t w;
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected reply word: data %h last %b user %b", $time, data, lst, user);
        errors++;
        return;
      end
      w = reply_q.pop_front();
      if (data !== w.tx_byte) begin
        $display("%0t: tx_byte expected %h actual %h", $time, w.tx_byte, data);
        errors++;
      end
      if (lst !== w.last) begin
        $display("%0t: last expected %b actual %b", $time, w.last, lst);
        errors++;
      end
      if (user[0] !== w.has_byte) begin
        $display("%0t: has_byte expected %b actual %b", $time, w.has_byte, user[0]);
        errors++;
      end
      if (user[2:1] !== w.outcome) begin
        $display("%0t: outcome expected %0d actual %0d", $time, w.outcome, user[2:1]);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return reply_q.size();
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;           // [7:0] tx_byte
  logic        out_tlast;
  logic [2:0]  out_tuser;           // [0] has_byte, [2:1] outcome
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index  = REG_START_CODE;
  logic [15:0] cfg_data   = 16'h0000;

  reply_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned bytes_sent    = 0;
  int unsigned hold_left     = 0;
  logic        hold_req      = 1'b0;

  fixed_frame_monitor_command_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watch both streams at the edge, seeing pre-edge values. Note the input word
  // first so that a same-edge reply word always finds its expectation queued.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.deframe_byte(in_tdata);
      if (out_tvalid && out_tready)
        sb.check_reply_word(out_tdata, out_tlast, out_tuser);
    end
  end

  // Receiver: random back-pressure, or a long hold-off once asked for, so that
  // a pending reply blocks the job register and the input stalls.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one word, with a random idle gap first; leave tvalid high on return
  // so the next word can follow back to back.
  task automatic send_byte(input byte_t b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Send a fixed frame; a nonzero sum_flip corrupts the checksum.
  task automatic send_frame(input byte_t ctrl, input logic [15:0] addr,
                            input byte_t sum_flip, input byte_t end_byte);
    byte_t sum;
    sum = ctrl + addr[7:0] + addr[15:8];
    send_byte(sb.start_code);
    send_byte(ctrl);
    send_byte(addr[7:0]);
    send_byte(addr[15:8]);
    send_byte(sum ^ sum_flip);
    send_byte(end_byte);
  endtask

  // Mostly well-formed frames with random content, the rest broken frames,
  // truncated frames and line noise.
  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned target;
    int unsigned r;
    int unsigned n;
    byte_t       ctrl;
    logic [15:0] addr;
    byte_t       flip;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      r = $urandom_range(99);
      if (r < 40)      ctrl = sb.fc_start;
      else if (r < 70) ctrl = sb.fc_stop;
      else             ctrl = byte_t'($urandom);
      r = $urandom_range(99);
      if (r < 20)      addr = sb.own_addr;
      else if (r < 30) addr = 16'h0000;
      else             addr = 16'($urandom);
      r = $urandom_range(99);
      if (r < 70) begin
        send_frame(ctrl, addr, 8'h00, sb.end_code);
      end else if (r < 80) begin
        flip = byte_t'($urandom_range(255, 1));
        if ($urandom_range(1) == 0) send_frame(ctrl, addr, flip, sb.end_code);
        else                        send_frame(ctrl, addr, 8'h00, sb.end_code ^ flip);
      end else if (r < 90) begin
        send_byte(sb.start_code);
        n = $urandom_range(4, 1);
        repeat (n) send_byte(byte_t'($urandom));
      end else begin
        n = $urandom_range(4, 1);
        repeat (n) send_byte(byte_t'($urandom));
      end
    end
  endtask

  // Drop tvalid and wait for every owed word, then idle on so that any stray word
  // still shows up before the next step.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(input byte_t sc, input byte_t ec, input byte_t fs,
                             input byte_t fp, input byte_t fr, input byte_t fe,
                             input logic [15:0] own, input logic md);
    cfg_write(REG_START_CODE,    {8'h00, sc});
    cfg_write(REG_END_CODE,      {8'h00, ec});
    cfg_write(REG_FC_START_MON,  {8'h00, fs});
    cfg_write(REG_FC_STOP_MON,   {8'h00, fp});
    cfg_write(REG_FC_REPLY,      {8'h00, fr});
    cfg_write(REG_FC_ADDR_ERROR, {8'h00, fe});
    cfg_write(REG_OWN_ADDR,      own);
    cfg_write(REG_PROTOCOL_MODE, {15'h0000, md});
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles lightly, receiver heavily.
    send_idle_pct = 22;
    recv_idle_pct = 88;

    // Directed words at the reset settings: noise before any start code,
    // a started reply, a clash on the zero address (no reply bytes),
    // a stop at the top address and an unknown function code.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(sb.fc_start, 16'h1234, 8'h00, sb.end_code);
    send_frame(sb.fc_start, 16'h0000, 8'h00, sb.end_code);
    send_frame(sb.fc_stop,  16'hFFFF, 8'h00, sb.end_code);
    send_frame(8'hFF,       16'h00FF, 8'h00, sb.end_code);
    random_traffic(55);

    settle();
    load_config(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
                byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
                16'($urandom), 1'b1);
    random_traffic(55);

    // Swap the idling: sender heavily, receiver lightly.
    settle();
    send_idle_pct = 88;
    recv_idle_pct = 22;
    // top extremes; start and stop share a code, so start must win
    load_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1);
    random_traffic(55);

    settle();
    load_config(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 16'h0000, 1'b0);
    random_traffic(55);

    // No idling on either side.
    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_config(8'h68, 8'h16, 8'h01, 8'h02, byte_t'($urandom), byte_t'($urandom),
                16'($urandom_range(255, 1)), 1'b0);
    random_traffic(55);

    // Hold the receiver off while frames keep coming, to fill the block.
    hold_req = 1'b1;
    random_traffic(100);

    settle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
